@@ sv/frame_rate_meter_seven_segment_defines.svh @@
// Assertion macros used by the checker file of the frame rate meter.
`ifndef FRAME_RATE_METER_SEVEN_SEGMENT_DEFINES_SVH
`define FRAME_RATE_METER_SEVEN_SEGMENT_DEFINES_SVH

// Checked on every rising clock edge while reset is released.
`define FRMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define FRMS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/frms_pkg.sv @@
`default_nettype none
package frms_pkg;

  localparam int unsigned IntervalWidth = 24;
  localparam int unsigned WindowWidth   = 24;
  localparam int unsigned CountWidth    = 24;
  localparam int unsigned ElapsedWidth  = 25;
  localparam int unsigned RateWidth     = 10;
  localparam int unsigned SegWidth      = 21;
  localparam int unsigned GlyphWidth    = 7;
  localparam int unsigned NumWidth      = 45;
  localparam int unsigned DenWidth      = ElapsedWidth + 1;
  localparam int unsigned QuoBits       = 10;

  localparam logic [WindowWidth-1:0] WindowReset = 24'd500000;
  localparam logic [RateWidth-1:0]   RateMax     = 10'd999;
  localparam logic [RateWidth-1:0]   RateNone    = 10'd1023;
  localparam logic [21:0]            TwoMillion  = 22'd2000000;

  localparam int unsigned QueueDepthDefault = 2;

  typedef struct packed {
    logic [CountWidth-1:0]   frames;
    logic [ElapsedWidth-1:0] elapsed;
  } window_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_SAT,
    B_DIV,
    B_HUND,
    B_TENS,
    B_EMIT
  } back_state_e;

  function automatic logic [GlyphWidth-1:0] digit_glyph(input logic [3:0] d);
    logic [GlyphWidth-1:0] g;
    case (d)
      4'd0: g = 7'h3F;
      4'd1: g = 7'h06;
      4'd2: g = 7'h5B;
      4'd3: g = 7'h4F;
      4'd4: g = 7'h66;
      4'd5: g = 7'h6D;
      4'd6: g = 7'h7D;
      4'd7: g = 7'h07;
      4'd8: g = 7'h7F;
      4'd9: g = 7'h6F;
      default: g = 7'h00;
    endcase
    return g;
  endfunction

  // Exact for values below 1000.
  function automatic logic [3:0] div100(input logic [RateWidth-1:0] r);
    logic [15:0] p;
    p = {6'd0, r} * 16'd41;
    return p[15:12];
  endfunction

  // Exact for values below 100.
  function automatic logic [3:0] div10(input logic [6:0] r);
    logic [13:0] p;
    p = {7'd0, r} * 14'd103;
    return p[13:10];
  endfunction

  function automatic logic [SegWidth-1:0] frms_encode(input logic [RateWidth-1:0] r);
    logic [3:0]  h;
    logic [10:0] hp;
    logic [6:0]  rest;
    logic [3:0]  t;
    logic [6:0]  tp;
    logic [3:0]  u;
    h    = div100(r);
    hp   = {7'd0, h} * 11'd100;
    rest = 7'(r - hp[RateWidth-1:0]);
    t    = div10(rest);
    tp   = {3'd0, t} * 7'd10;
    u    = 4'(rest - tp);
    return {digit_glyph(u), digit_glyph(t), digit_glyph(h)};
  endfunction

endpackage
`default_nettype wire

@@ sv/frms_front.sv @@
`default_nettype none
module frms_front
  import frms_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     accept_i,
  input  wire logic [IntervalWidth-1:0] interval_us_i,
  input  wire logic                     cfg_we_i,
  input  wire logic [WindowWidth-1:0]   window_us_i,
  output      logic                     q_push_o,
  output      window_t                  q_data_o
);

  logic [WindowWidth-1:0]  window_q;
  logic [CountWidth-1:0]   frames_q, frames_d;
  logic [ElapsedWidth-1:0] elapsed_q, elapsed_d;
  logic [CountWidth-1:0]   frames_inc;
  logic [ElapsedWidth-1:0] elapsed_sum;
  logic                    frame;
  logic                    closes;

  assign frame       = accept_i && (interval_us_i != '0);
  assign frames_inc  = frames_q + 1'b1;
  assign elapsed_sum = elapsed_q + {1'b0, interval_us_i};
  assign closes      = elapsed_sum >= {1'b0, window_q};

  always_comb begin
    frames_d  = frames_q;
    elapsed_d = elapsed_q;
    q_push_o  = 1'b0;
    if (frame) begin
      if (closes) begin
        frames_d  = '0;
        elapsed_d = '0;
        q_push_o  = 1'b1;
      end else begin
        frames_d  = frames_inc;
        elapsed_d = elapsed_sum;
      end
    end
  end

  assign q_data_o = '{frames: frames_inc, elapsed: elapsed_sum};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= WindowReset;
      frames_q  <= '0;
      elapsed_q <= '0;
    end else begin
      if (cfg_we_i) begin
        window_q <= window_us_i;
      end
      frames_q  <= frames_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/frms_queue.sv @@
`default_nettype none
module frms_queue
  import frms_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire window_t data_i,
  output      logic    full_o,
  input  wire logic    pop_i,
  output      window_t data_o,
  output      logic    empty_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

  window_t               mem_q [Depth];
  logic [PtrWidth-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0]   cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/frms_back.sv @@
`default_nettype none
module frms_back
  import frms_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_empty_i,
  input  wire window_t              q_data_i,
  output      logic                 q_pop_o,
  output      logic                 empty_o,
  input  wire logic                 pop_i,
  output      logic [SegWidth-1:0]  segments_o,
  output      logic [RateWidth-1:0] rate_o
);

  back_state_e state_q, state_d;

  logic [CountWidth-1:0]   frames_q;
  logic [ElapsedWidth-1:0] elapsed_q;
  logic [DenWidth-1:0]     den_q;
  logic [NumWidth-1:0]     rem_q;
  logic [QuoBits-1:0]      quo_q;
  logic [3:0]              step_q;
  logic [RateWidth-1:0]    rate_q;
  logic [3:0]              hund_q;
  logic [6:0]              rest_q;
  logic [RateWidth-1:0]    shown_q;
  logic                    out_valid_q;
  logic [SegWidth-1:0]     out_seg_q;
  logic [RateWidth-1:0]    out_rate_q;

  logic [NumWidth-1:0]     num;
  logic [NumWidth-1:0]     sat_bound;
  logic [NumWidth-1:0]     trial;
  logic                    fits;
  logic                    saturate;
  logic [3:0]              tens;
  logic [6:0]              tens_x10;
  logic [3:0]              units;
  logic [10:0]             hund_x100;
  logic [RateWidth-1:0]    quo_clamped;
  logic                    changed;
  logic                    out_free;
  logic                    load_out;

  assign num         = {21'd0, frames_q} * {23'd0, TwoMillion} + {20'd0, elapsed_q};
  assign sat_bound   = NumWidth'({den_q, 10'd0});
  assign saturate    = rem_q >= sat_bound;
  assign trial       = NumWidth'({den_q, 9'd0} >> (4'd9 - step_q));
  assign fits        = rem_q >= trial;
  assign quo_clamped = (quo_q > RateMax) ? RateMax : quo_q;
  assign hund_x100   = {7'd0, div100(rate_q)} * 11'd100;
  assign tens        = div10(rest_q);
  assign tens_x10    = {3'd0, tens} * 7'd10;
  assign units       = 4'(rest_q - tens_x10);
  assign changed     = rate_q != shown_q;
  assign out_free    = !out_valid_q || pop_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          state_d = B_MUL;
        end
      end
      B_MUL:  state_d = B_SAT;
      B_SAT:  state_d = saturate ? B_HUND : B_DIV;
      B_DIV: begin
        if (step_q == '0) begin
          state_d = B_HUND;
        end
      end
      B_HUND: state_d = B_TENS;
      B_TENS: state_d = B_EMIT;
      B_EMIT: begin
        if (!changed || out_free) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o  = 1'b0;
    load_out = 1'b0;
    case (state_q)
      B_IDLE:  q_pop_o  = !q_empty_i;
      B_EMIT:  load_out = changed && out_free;
      default: begin
        q_pop_o  = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        frames_q  <= q_data_i.frames;
        elapsed_q <= q_data_i.elapsed;
      end
      B_MUL: begin
        rem_q <= num;
        den_q <= {elapsed_q, 1'b0};
      end
      B_SAT: begin
        step_q <= 4'd9;
        quo_q  <= saturate ? RateMax : '0;
      end
      B_DIV: begin
        if (fits) begin
          rem_q <= rem_q - trial;
        end
        quo_q  <= {quo_q[QuoBits-2:0], fits};
        step_q <= step_q - 1'b1;
      end
      B_HUND: begin
        rate_q <= quo_clamped;
      end
      B_TENS: begin
        hund_q <= div100(rate_q);
        rest_q <= 7'(rate_q - hund_x100[RateWidth-1:0]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_seg_q  <= {digit_glyph(units), digit_glyph(tens), digit_glyph(hund_q)};
      out_rate_q <= rate_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      shown_q     <= RateNone;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        shown_q     <= rate_q;
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty_o    = !out_valid_q;
  assign segments_o = out_seg_q;
  assign rate_o     = out_rate_q;

endmodule
`default_nettype wire

@@ sv/frame_rate_meter_seven_segment.sv @@
// Frame rate meter with a three-digit seven-segment readout.
// Input queue side: present interval_us_i and raise push; the event is taken
// at a clock edge where full is low. A zero interval is taken and ignored.
// Frame events are taken one per cycle while full is low; full rises only
// when closed windows pile up in the internal queue faster than the rate
// unit drains them. Result queue side: while empty is low, rate_o and
// segments_o hold the newest changed rate; raising pop takes it. A result
// appears only when a window closes with a rate that differs from the last
// one delivered. On the way to empty going low, the rate unit runs the
// ten-step restoring divider unless the rate saturates; it takes the next
// closed window from the queue only when it is done with the last one.
// If pop stays low, the finished result is held, the rate unit waits with
// the next one, the queue fills, and then full stops further events.
// The window length is written through cfg_valid_i/window_us_i; cfg_ready_o
// is always high. Reset sets the window to 500000 us, clears the counters,
// empties both queues and marks no rate as shown yet.
`default_nettype none
module frame_rate_meter_seven_segment
  import frms_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push,
  output      logic                     full,
  input  wire logic [IntervalWidth-1:0] interval_us_i,
  output      logic                     empty,
  input  wire logic                     pop,
  output      logic [SegWidth-1:0]      segments_o,
  output      logic [RateWidth-1:0]     rate_o,
  input  wire logic                     cfg_valid_i,
  output      logic                     cfg_ready_o,
  input  wire logic [WindowWidth-1:0]   window_us_i
);

  logic    q_push, q_full, q_pop, q_empty;
  window_t q_wdata, q_rdata;

  assign full        = q_full;
  assign cfg_ready_o = 1'b1;

  frms_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (push && !q_full),
    .interval_us_i (interval_us_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .window_us_i   (window_us_i),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  frms_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  frms_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .segments_o (segments_o),
    .rate_o     (rate_o)
  );

endmodule
`default_nettype wire

@@ sv/frms_checker.sv @@
`default_nettype none
`include "frame_rate_meter_seven_segment_defines.svh"
module frms_checker
  import frms_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 empty,
  input wire logic                 pop,
  input wire logic [SegWidth-1:0]  segments_o,
  input wire logic [RateWidth-1:0] rate_o
);

  logic                 have_q;
  logic [RateWidth-1:0] last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      last_q <= RateNone;
    end else if (pop && !empty) begin
      have_q <= 1'b1;
      last_q <= rate_o;
    end
  end

  `FRMS_ASSERT_ALWAYS(reset_empty_a, !rst_ni |-> empty, "result queue not empty in reset")
  `FRMS_ASSERT(rate_range_a, !empty |-> rate_o <= RateMax, "rate above 999")
  `FRMS_ASSERT(seg_match_a, !empty |-> segments_o == frms_encode(rate_o), "segments mismatch")
  `FRMS_ASSERT(rate_changed_a, (!empty && have_q) |-> rate_o != last_q, "repeated rate")
  `FRMS_ASSERT(hold_a, (!empty && !pop) |=> (!empty && $stable(rate_o)), "result dropped")

endmodule

bind frame_rate_meter_seven_segment frms_checker u_checker (.*);
`default_nettype wire
